// ===== src/pctd_pkg.sv =====
// Package: shared constants and the sequencer state type for the prime counter.
`timescale 1ns / 1ps
package pctd_pkg;

   localparam int ValueWidthDefault = 32;
   localparam int CountWidthDefault = 16;
   localparam int PrimeCountWidth   = 16;
   localparam int FirstOddDivisor   = 3;
   localparam int DivisorStep       = 2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_FINISH
   } pctd_state_type;

endpackage

// ===== src/pctd_req_if.sv =====
// Interface: input channel carrying the value to test and the array markers.
`timescale 1ns / 1ps
interface pctd_req_if import pctd_pkg::*; #(
   parameter int VALUE_WIDTH = ValueWidthDefault
) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic                          first;
   logic                          last;

   modport source (output valid, output value, output first, output last, input ready);
   modport sink   (input valid, input value, input first, input last, output ready);
endinterface

// ===== src/pctd_rsp_if.sv =====
// Interface: result channel carrying the prime flag, the running count and the end marker.
`timescale 1ns / 1ps
interface pctd_rsp_if import pctd_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       is_prime;
   logic [PrimeCountWidth-1:0] prime_count;
   logic                       end_of_array;

   modport source (output valid, output is_prime, output prime_count,
                   output end_of_array, input ready);
   modport sink   (input valid, input is_prime, input prime_count,
                   input end_of_array, output ready);
endinterface

// ===== src/prime_count_trial_division.sv =====
// Top level: trial-division primality test with a per-array running prime count.
//
//   channel   dir   handshake          payload
//   req_chan  in    valid / ready      value, first, last
//   rsp_chan  out   valid / ready      is_prime, prime_count, end_of_array
//
// One item at a time. Negative, 0, 1 and even values skip the divider.
// Odd values run odd divisors from 3 through one shared restoring divider,
// one LAUNCH and DIVIDE pass per divisor; a 32-bit prime near the top takes about
// 23170 divisors.
// Reset is synchronous and clears the sequencer, count and result valid.
// A held result stalls only the finish step; the next item waits for IDLE.
`timescale 1ns / 1ps
module prime_count_trial_division import pctd_pkg::*; #(
   parameter int VALUE_WIDTH = ValueWidthDefault,
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic         clock,
   input  logic         reset,
   pctd_req_if.sink     req_chan,
   pctd_rsp_if.source   rsp_chan
);

   localparam int MagWidth     = VALUE_WIDTH - 1;
   localparam int CountExWidth = (COUNT_WIDTH > PrimeCountWidth) ? COUNT_WIDTH
                                                                 : PrimeCountWidth;

   pctd_state_type state_ff, state_in;

   logic [MagWidth-1:0]    v_ff, v_in;
   logic [MagWidth-1:0]    d_ff, d_in;
   logic                   first_ff, first_in;
   logic                   last_ff, last_in;
   logic                   prime_ff, prime_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;
   logic [PrimeCountWidth-1:0] rsp_count_ff, rsp_count_in;
   logic                   rsp_end_ff, rsp_end_in;

   logic                   req_accept;
   logic                   rsp_load;
   logic                   div_start;
   logic                   div_done;
   logic [MagWidth-1:0]    div_quo;
   logic [MagWidth-1:0]    div_rem;
   logic [MagWidth-1:0]    req_mag;
   logic                   req_neg;
   logic                   req_trivial;
   logic                   req_trivial_prime;
   logic                   div_past_root;
   logic                   div_exact;
   logic [COUNT_WIDTH-1:0] count_base;
   logic [CountExWidth-1:0] count_wide;

   pctd_divider #(.WIDTH(MagWidth)) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (v_ff),
      .divisor   (d_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign req_accept = req_chan.valid && req_chan.ready;
   assign req_neg    = req_chan.value[VALUE_WIDTH-1];
   assign req_mag    = req_chan.value[MagWidth-1:0];

   // negatives, values below two and even values need no division
   assign req_trivial       = req_neg || (req_mag < MagWidth'(2)) || !req_mag[0];
   assign req_trivial_prime = !req_neg && (req_mag == MagWidth'(2));

   // d > v / d means d * d > v: no divisor left
   assign div_past_root = (d_ff > div_quo);
   assign div_exact     = (div_rem == '0);

   assign rsp_load = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_chan.ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) state_in = req_trivial ? ST_FINISH : ST_LAUNCH;
         end
         ST_LAUNCH: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (div_done) state_in = (div_past_root || div_exact) ? ST_FINISH : ST_LAUNCH;
         end
         ST_FINISH: begin
            if (rsp_load) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_chan.ready = 1'b1;
         ST_LAUNCH: div_start      = 1'b1;
         ST_DIVIDE,
         ST_FINISH: ;
         default:   ;
      endcase
   end

   // datapath
   always_comb begin
      v_in     = v_ff;
      d_in     = d_ff;
      first_in = first_ff;
      last_in  = last_ff;
      prime_in = prime_ff;
      if (req_accept) begin
         v_in     = req_mag;
         d_in     = MagWidth'(FirstOddDivisor);
         first_in = req_chan.first;
         last_in  = req_chan.last;
         prime_in = req_trivial_prime;
      end else if ((state_ff == ST_DIVIDE) && div_done) begin
         prime_in = div_past_root;
         d_in     = d_ff + MagWidth'(DivisorStep);
      end
   end

   always_comb begin
      count_base = first_ff ? '0 : count_ff;
      count_in   = count_ff;
      if (rsp_load) begin
         count_in = count_base;
         if (prime_ff && (count_base != '1)) count_in = count_base + COUNT_WIDTH'(1);
      end
   end

   assign count_wide = CountExWidth'(count_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_prime_in = rsp_prime_ff;
      rsp_count_in = rsp_count_ff;
      rsp_end_in   = rsp_end_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_prime_in = prime_ff;
         rsp_count_in = count_wide[PrimeCountWidth-1:0];
         rsp_end_in   = last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      v_ff         <= v_in;
      d_ff         <= d_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      prime_ff     <= prime_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_count_ff <= rsp_count_in;
      rsp_end_ff   <= rsp_end_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.is_prime     = rsp_prime_ff;
   assign rsp_chan.prime_count  = rsp_count_ff;
   assign rsp_chan.end_of_array = rsp_end_ff;

   // an accepted item always leaves IDLE
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   // the divider only reports back while the sequencer waits for it
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside divide state");

   // trial divisors stay odd and at least three
   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (d_ff[0] && (d_ff >= MagWidth'(FirstOddDivisor))))
      else $error("trial divisor not odd or below three");

   // within an array the count never falls
   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && !first_ff) |=> (count_ff >= $past(count_ff)))
      else $error("running count decreased inside an array");

endmodule

// ===== src/pctd_divider.sv =====
// Module: restoring divider, one quotient bit per cycle, unsigned operands.
`timescale 1ns / 1ps
module pctd_divider import pctd_pkg::*; #(
   parameter int WIDTH = ValueWidthDefault - 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic [WIDTH-1:0] remainder
);

   localparam int CntWidth = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]    quo_ff, quo_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH:0]      trial;
   logic [WIDTH:0]      diff;
   logic                last_step;

   // divisor must stay stable while busy
   assign trial     = {rem_ff, quo_ff[WIDTH-1]};
   assign diff      = trial - {1'b0, divisor};
   assign last_step = (cnt_ff == CntWidth'(WIDTH - 1));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      if (busy_ff) begin
         if (diff[WIDTH]) begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff + CntWidth'(1);
         if (last_step) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
